@@ rtl/core/offs_pkg.sv @@
// Package for the oldest-first frame selector: sizes, operation codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package offs_pkg;

  // Block sizing
  localparam int NumCameras     = 5;
  localparam int MaxPerTransfer = 3;
  localparam int PayloadWidth   = 32;

  // Port field widths (fixed by the interface)
  localparam int OpW   = 2;
  localparam int CamW  = 3;
  localparam int TimeW = 48;
  localparam int PayW  = 32;

  // Derived widths
  localparam int IdxW = (NumCameras > 1) ? $clog2(NumCameras) : 1;
  localparam int CntW = $clog2(MaxPerTransfer + 1);

  typedef enum logic [OpW-1:0] {
    OP_UPDATE = 2'd0,
    OP_BUILD  = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic update;  // store the accepted frame
    logic remove;  // invalidate the last-sent set
    logic start;   // open a build
    logic step;    // examine one slot of the scan
    logic load;    // move the pass winner into the output register
  } offs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // current slot is the final one of the pass
    logic out_free;   // output register can take a beat this cycle
    logic run_last;   // the pending result closes the build
  } offs_status_t;

endpackage

@@ rtl/core/offs_dpath.sv @@
// Datapath of the oldest-first frame selector: slot storage, last-sent set,
// scan comparator, age arithmetic and output register.
// Depends on offs_pkg.
`timescale 1ns / 1ps

module offs_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  offs_pkg::offs_cmd_t           cmd_i,
  output offs_pkg::offs_status_t        status_o,
  input  logic [offs_pkg::CamW-1:0]     camera_i,
  input  logic [offs_pkg::TimeW-1:0]    frame_age_i,
  input  logic [offs_pkg::PayW-1:0]     frame_payload_i,
  input  logic [offs_pkg::TimeW-1:0]    now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          frame_valid_o,
  output logic [offs_pkg::CamW-1:0]     out_camera_o,
  output logic [offs_pkg::TimeW-1:0]    out_age_o,
  output logic [offs_pkg::PayW-1:0]     out_payload_o,
  output logic                          last_of_run_o
);

  // Slot storage
  logic [offs_pkg::NumCameras-1:0]   slot_valid_q, slot_valid_d;
  logic [offs_pkg::TimeW-1:0]        slot_time_q [offs_pkg::NumCameras];
  logic [offs_pkg::PayloadWidth-1:0] slot_pay_q  [offs_pkg::NumCameras];
  logic [offs_pkg::NumCameras-1:0]   last_sent_q, last_sent_d;

  // Build state
  logic [offs_pkg::NumCameras-1:0]   chosen_q, chosen_d;
  logic [offs_pkg::TimeW-1:0]        now_q;
  logic [offs_pkg::IdxW-1:0]         idx_q, idx_d;
  logic [offs_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic                              found_q, found_d;
  logic [offs_pkg::IdxW-1:0]         best_idx_q;
  logic [offs_pkg::TimeW-1:0]        best_time_q;
  logic [offs_pkg::PayloadWidth-1:0] best_pay_q;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic                              frame_valid_q;
  logic [offs_pkg::CamW-1:0]         out_camera_q;
  logic [offs_pkg::TimeW-1:0]        out_age_q;
  logic [offs_pkg::PayW-1:0]         out_payload_q;
  logic                              last_of_run_q;

  logic                              cam_ok;
  logic [offs_pkg::IdxW-1:0]         cam_idx;
  logic [offs_pkg::TimeW-1:0]        stamp_time;
  logic                              cand;
  logic                              better;
  logic [offs_pkg::NumCameras-1:0]   chosen_new;
  logic                              run_last;
  logic [offs_pkg::TimeW-1:0]        best_age;
  logic                              out_free;

  // Decode the update target and clamp its capture time at zero
  assign cam_ok     = int'(camera_i) < offs_pkg::NumCameras;
  assign cam_idx    = offs_pkg::IdxW'(camera_i);
  assign stamp_time = (frame_age_i > now_time_i) ? '0 : now_time_i - frame_age_i;

  // Compare the scanned slot against the pass winner so far
  assign cand   = slot_valid_q[idx_q] && !chosen_q[idx_q];
  assign better = cand && (!found_q || (slot_time_q[idx_q] < best_time_q));

  // Close the pass: add the winner and see whether anything is left
  always_comb begin
    chosen_new = chosen_q;
    if (found_q) begin
      chosen_new[best_idx_q] = 1'b1;
    end
  end

  assign run_last = !found_q
                 || (cnt_q == offs_pkg::CntW'(offs_pkg::MaxPerTransfer - 1))
                 || ((slot_valid_q & ~chosen_new) == '0);
  assign best_age = (now_q >= best_time_q) ? now_q - best_time_q : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next values of the control registers
  always_comb begin
    slot_valid_d = slot_valid_q;
    last_sent_d  = last_sent_q;
    chosen_d     = chosen_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (cmd_i.update && cam_ok) begin
      slot_valid_d[cam_idx] = 1'b1;
      last_sent_d[cam_idx]  = 1'b0;
    end
    if (cmd_i.remove) begin
      slot_valid_d = slot_valid_q & ~last_sent_q;
      last_sent_d  = '0;
    end
    if (cmd_i.start) begin
      chosen_d = '0;
      idx_d    = '0;
      cnt_d    = '0;
      found_d  = 1'b0;
    end
    if (cmd_i.step) begin
      if (better) begin
        found_d = 1'b1;
      end
      idx_d = status_o.scan_last ? '0 : idx_q + 1'b1;
    end
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      chosen_d    = chosen_new;
      cnt_d       = cnt_q + 1'b1;
      found_d     = 1'b0;
      if (run_last) begin
        last_sent_d = chosen_new;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      last_sent_q  <= '0;
      chosen_q     <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
      last_sent_q  <= last_sent_d;
      chosen_q     <= chosen_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Slot contents, written on update only
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && cam_ok) begin
      slot_time_q[cam_idx] <= stamp_time;
      slot_pay_q[cam_idx]  <= offs_pkg::PayloadWidth'(frame_payload_i);
    end
  end

  // Hold the build time and the pass winner
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      now_q <= now_time_i;
    end
    if (cmd_i.step && better) begin
      best_idx_q  <= idx_q;
      best_time_q <= slot_time_q[idx_q];
      best_pay_q  <= slot_pay_q[idx_q];
    end
  end

  // Output payload; an empty build gives all-zero fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_valid_q <= found_q;
      last_of_run_q <= run_last;
      if (found_q) begin
        out_camera_q  <= offs_pkg::CamW'(best_idx_q);
        out_age_q     <= best_age;
        out_payload_q <= offs_pkg::PayW'(best_pay_q);
      end else begin
        out_camera_q  <= '0;
        out_age_q     <= '0;
        out_payload_q <= '0;
      end
    end
  end

  assign status_o.scan_last = (idx_q == offs_pkg::IdxW'(offs_pkg::NumCameras - 1));
  assign status_o.out_free  = out_free;
  assign status_o.run_last  = run_last;

  assign out_valid_o   = out_valid_q;
  assign frame_valid_o = frame_valid_q;
  assign out_camera_o  = out_camera_q;
  assign out_age_o     = out_age_q;
  assign out_payload_o = out_payload_q;
  assign last_of_run_o = last_of_run_q;

endmodule

@@ rtl/core/offs_ctrl.sv @@
// Controller of the oldest-first frame selector: decodes accepted beats and
// sequences the scan passes of a build.
// Depends on offs_pkg.
`timescale 1ns / 1ps

module offs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [offs_pkg::OpW-1:0]   operation_i,
  input  offs_pkg::offs_status_t     status_i,
  output offs_pkg::offs_cmd_t        cmd_o
);

  offs_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_stall_o = (state_q != offs_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      offs_pkg::ST_IDLE: begin
        if (accept && (offs_pkg::op_e'(operation_i) == offs_pkg::OP_BUILD)) begin
          state_d = offs_pkg::ST_SCAN;
        end
      end
      offs_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = offs_pkg::ST_LOAD;
        end
      end
      offs_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.run_last ? offs_pkg::ST_IDLE : offs_pkg::ST_SCAN;
        end
      end
      default: state_d = offs_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '0;
    case (state_q)
      offs_pkg::ST_IDLE: begin
        if (accept) begin
          case (offs_pkg::op_e'(operation_i))
            offs_pkg::OP_UPDATE: cmd_o.update = 1'b1;
            offs_pkg::OP_BUILD:  cmd_o.start  = 1'b1;
            offs_pkg::OP_REMOVE: cmd_o.remove = 1'b1;
            default:             cmd_o        = '0;
          endcase
        end
      end
      offs_pkg::ST_SCAN: cmd_o.step = 1'b1;
      offs_pkg::ST_LOAD: cmd_o.load = status_i.out_free;
      default:           cmd_o      = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= offs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/oldest_first_frame_selector.sv @@
// Oldest-first frame selector: one slot per camera, builds send the oldest
// valid frames first. Update and remove are applied on acceptance; a build gives
// its first result beat after a full slot scan and a load into the output register.
// A build runs up to 3 scan passes, one over the single slot read port per
// result; further input waits until its last beat is loaded.
// Reset clears slot valid marks, the last-sent set and all control; slot data is not cleared.
`timescale 1ns / 1ps

module oldest_first_frame_selector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [offs_pkg::OpW-1:0]   operation_i,
  input  logic [offs_pkg::CamW-1:0]  camera_i,
  input  logic [offs_pkg::TimeW-1:0] frame_age_i,
  input  logic [offs_pkg::PayW-1:0]  frame_payload_i,
  input  logic [offs_pkg::TimeW-1:0] now_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       frame_valid_o,
  output logic [offs_pkg::CamW-1:0]  out_camera_o,
  output logic [offs_pkg::TimeW-1:0] out_age_o,
  output logic [offs_pkg::PayW-1:0]  out_payload_o,
  output logic                       last_of_run_o
);

  offs_pkg::offs_cmd_t    cmd;
  offs_pkg::offs_status_t status;

  // Sequence the operations
  offs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Store slots, scan and drive the result beats
  offs_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .camera_i        (camera_i),
    .frame_age_i     (frame_age_i),
    .frame_payload_i (frame_payload_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_valid_o   (frame_valid_o),
    .out_camera_o    (out_camera_o),
    .out_age_o       (out_age_o),
    .out_payload_o   (out_payload_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

@@ rtl/core/offs_checker.sv @@
// Port-level checker for the oldest-first frame selector, bound to the top level.
// Depends on offs_pkg and oldest_first_frame_selector.
`timescale 1ns / 1ps

module offs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [offs_pkg::OpW-1:0]   operation_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       frame_valid_o,
  input logic [offs_pkg::CamW-1:0]  out_camera_o,
  input logic [offs_pkg::TimeW-1:0] out_age_o,
  input logic [offs_pkg::PayW-1:0]  out_payload_o,
  input logic                       last_of_run_o
);

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_age_o)
      && $stable(out_camera_o) && $stable(out_payload_o) && $stable(last_of_run_o))
    else $error("stalled result beat changed");

  // An accepted build blocks further input while it scans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == offs_pkg::OP_BUILD) |=> in_stall_o)
    else $error("input accepted during a build scan");

  // An empty build is a single closing beat with zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_valid_o |-> last_of_run_o && (out_camera_o == '0)
      && (out_age_o == '0) && (out_payload_o == '0))
    else $error("malformed empty result");

  // A frame beat names an existing camera
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_valid_o |-> int'(out_camera_o) < offs_pkg::NumCameras)
    else $error("result camera out of range");

endmodule

bind oldest_first_frame_selector offs_checker u_offs_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for oldest_first_frame_selector: directed corner cases,
// a long output hold-off and random traffic, checked beat by beat against a predictor.
// Depends on offs_pkg and the oldest_first_frame_selector RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [offs_pkg::OpW-1:0]   OpUnused = 2'd3;
  localparam logic [offs_pkg::TimeW-1:0] TimeMax  = {offs_pkg::TimeW{1'b1}};
  localparam logic [offs_pkg::PayW-1:0]  PayMax   = {offs_pkg::PayW{1'b1}};
  localparam int               IdlePercent    = 18;
  localparam int               QuietLimit     = 1000;
  localparam int               DrainCycles    = 24;
  localparam int               HoldOffCycles  = 120;
  localparam int               RandomItems    = 335;
  localparam int               SteadyItems    = 60;

  // One result beat as the block presents it
  typedef struct packed {
    logic                       frame_valid;
    logic [offs_pkg::CamW-1:0]  camera;
    logic [offs_pkg::TimeW-1:0] age;
    logic [offs_pkg::PayW-1:0]  payload;
    logic                       last_of_run;
  } frame_beat_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [offs_pkg::OpW-1:0]   operation_i     = '0;
  logic [offs_pkg::CamW-1:0]  camera_i        = '0;
  logic [offs_pkg::TimeW-1:0] frame_age_i     = '0;
  logic [offs_pkg::PayW-1:0]  frame_payload_i = '0;
  logic [offs_pkg::TimeW-1:0] now_time_i      = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic                       frame_valid_o;
  logic [offs_pkg::CamW-1:0]  out_camera_o;
  logic [offs_pkg::TimeW-1:0] out_age_o;
  logic [offs_pkg::PayW-1:0]  out_payload_o;
  logic                       last_of_run_o;

  // Predictor copy of the slot store
  logic                            slot_live [offs_pkg::NumCameras];
  logic [offs_pkg::TimeW-1:0]      slot_taken_at [offs_pkg::NumCameras];
  logic [offs_pkg::PayW-1:0]       slot_data [offs_pkg::NumCameras];
  logic [offs_pkg::NumCameras-1:0] sent_set;
  frame_beat_t                     pending_beats [$];

  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          rx_hold_len    = 0;
  int          hold_left      = 0;
  bit          tx_idle_on     = 1'b0;
  bit          rx_idle_on     = 1'b0;
  logic [offs_pkg::TimeW-1:0] clock_now = '0;

  oldest_first_frame_selector u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .camera_i        (camera_i),
    .frame_age_i     (frame_age_i),
    .frame_payload_i (frame_payload_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_valid_o   (frame_valid_o),
    .out_camera_o    (out_camera_o),
    .out_age_o       (out_age_o),
    .out_payload_o   (out_payload_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [offs_pkg::TimeW-1:0] wide_time();
    return offs_pkg::TimeW'({$urandom, $urandom});
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Apply one accepted beat to the slot store and queue the results it causes
  task automatic predict_selection(input logic [offs_pkg::OpW-1:0] op,
                                   input logic [offs_pkg::CamW-1:0] cam,
                                   input logic [offs_pkg::TimeW-1:0] age,
                                   input logic [offs_pkg::PayW-1:0] pay,
                                   input logic [offs_pkg::TimeW-1:0] now);
    logic [offs_pkg::NumCameras-1:0] chosen;
    int                              picked [offs_pkg::MaxPerTransfer];
    int                              n_picked;
    int                              best;
    frame_beat_t                     beat;
    chosen   = '0;
    n_picked = 0;
    case (op)
      offs_pkg::OP_UPDATE: begin
        if (cam < offs_pkg::NumCameras) begin
          slot_taken_at[cam] = (age > now) ? '0 : now - age;
          slot_data[cam]     = pay;
          slot_live[cam]     = 1'b1;
          sent_set[cam]      = 1'b0;
        end
      end
      offs_pkg::OP_BUILD: begin
        // Pick oldest capture first, lower camera wins a tie
        while (n_picked < offs_pkg::MaxPerTransfer) begin
          best = -1;
          for (int i = 0; i < offs_pkg::NumCameras; i++) begin
            if (slot_live[i] && !chosen[i] &&
                (best < 0 || slot_taken_at[i] < slot_taken_at[best])) begin
              best = i;
            end
          end
          if (best < 0) break;
          chosen[best]       = 1'b1;
          picked[n_picked++] = best;
        end
        sent_set = chosen;
        if (n_picked == 0) begin
          beat = '{1'b0, '0, '0, '0, 1'b1};
          pending_beats = {pending_beats, beat};
        end
        for (int k = 0; k < n_picked; k++) begin
          beat.frame_valid = 1'b1;
          beat.camera      = offs_pkg::CamW'(picked[k]);
          beat.age         = (now >= slot_taken_at[picked[k]]) ?
                             now - slot_taken_at[picked[k]] : '0;
          beat.payload     = slot_data[picked[k]];
          beat.last_of_run = (k == n_picked - 1);
          pending_beats = {pending_beats, beat};
        end
      end
      offs_pkg::OP_REMOVE: begin
        for (int i = 0; i < offs_pkg::NumCameras; i++) begin
          if (sent_set[i]) slot_live[i] = 1'b0;
        end
        sent_set = '0;
      end
      default: ;
    endcase
  endtask

  // Watch both channels: predict on input beats, compare on output beats
  always @(posedge clk_i) begin : beat_monitor
    frame_beat_t got_beat;
    frame_beat_t want_beat;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) begin
        quiet_cycles = 0;
        predict_selection(operation_i, camera_i, frame_age_i, frame_payload_i, now_time_i);
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        got_beat = '{frame_valid_o, out_camera_o, out_age_o, out_payload_o, last_of_run_o};
        if (pending_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending", 64'(got_beat.camera), 64'd0);
        end else begin
          want_beat = pending_beats.pop_front();
          if (got_beat.frame_valid !== want_beat.frame_valid)
            report_mismatch("frame_valid", 64'(got_beat.frame_valid), 64'(want_beat.frame_valid));
          if (got_beat.camera !== want_beat.camera)
            report_mismatch("out_camera", 64'(got_beat.camera), 64'(want_beat.camera));
          if (got_beat.age !== want_beat.age)
            report_mismatch("out_age", 64'(got_beat.age), 64'(want_beat.age));
          if (got_beat.payload !== want_beat.payload)
            report_mismatch("out_payload", 64'(got_beat.payload), 64'(want_beat.payload));
          if (got_beat.last_of_run !== want_beat.last_of_run)
            report_mismatch("last_of_run", 64'(got_beat.last_of_run),
                            64'(want_beat.last_of_run));
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (rx_hold_len != 0) begin
      hold_left   = rx_hold_len;
      rx_hold_len = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(99) < IdlePercent);
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    wait (rst_ni);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[oldest_first_frame_selector] ERROR");
    $finish;
  end

  // Offer one beat and hold it until the block takes it
  task automatic send_beat(input logic [offs_pkg::OpW-1:0] op,
                           input logic [offs_pkg::CamW-1:0] cam,
                           input logic [offs_pkg::TimeW-1:0] age,
                           input logic [offs_pkg::PayW-1:0] pay,
                           input logic [offs_pkg::TimeW-1:0] now);
    while (tx_idle_on && ($urandom_range(99) < IdlePercent)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    camera_i        <= cam;
    frame_age_i     <= age;
    frame_payload_i <= pay;
    now_time_i      <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic test_corner_cases();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // Empty store, unused code and out-of-range cameras
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, '0);
    send_beat(OpUnused, 3'd7, TimeMax, PayMax, TimeMax);
    send_beat(offs_pkg::OP_UPDATE, 3'd7, '0, PayMax, 48'd5);
    send_beat(offs_pkg::OP_UPDATE, 3'd5, 48'd1, 32'h1234_5678, 48'd5);
    send_beat(offs_pkg::OP_UPDATE, 3'd6, 48'd2, 32'h8765_4321, 48'd5);
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, TimeMax);
    // Age beyond now clamps; now before capture saturates the age
    send_beat(offs_pkg::OP_UPDATE, 3'd0, TimeMax, '0, '0);
    send_beat(offs_pkg::OP_UPDATE, 3'd4, '0, PayMax, TimeMax);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, TimeMax);
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, 48'd7);
    // Full store with a tie between cameras one and two
    send_beat(offs_pkg::OP_UPDATE, 3'd1, 48'd10, 32'hA5A5_0001, 48'd100);
    send_beat(offs_pkg::OP_UPDATE, 3'd2, 48'd20, 32'h5A5A_0002, 48'd110);
    send_beat(offs_pkg::OP_UPDATE, 3'd3, 48'd5, 32'h0000_0003, 48'd50);
    send_beat(offs_pkg::OP_UPDATE, 3'd0, 48'd1, 32'hFFFF_0000, 48'd200);
    send_beat(offs_pkg::OP_UPDATE, 3'd4, 48'd100, 32'h0000_FFFF, 48'd100);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, 48'd300);
    // A fresh update drops camera three from the last-sent set
    send_beat(offs_pkg::OP_UPDATE, 3'd3, '0, 32'hC0DE_0003, 48'd301);
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, 48'd400);
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, 48'd401);
  endtask

  task automatic test_output_hold_off();
    tx_idle_on  = 1'b0;
    rx_hold_len = HoldOffCycles;
    // Fill every slot, then keep offering builds into the held output
    for (int i = 0; i < offs_pkg::NumCameras; i++) begin
      send_beat(offs_pkg::OP_UPDATE, offs_pkg::CamW'(i), 48'($urandom_range(50)),
                $urandom, 48'd1000);
    end
    for (int i = 0; i < 6; i++) begin
      send_beat(offs_pkg::OP_BUILD, offs_pkg::CamW'($urandom), '0, $urandom,
                48'(1000 + i));
    end
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
    send_beat(offs_pkg::OP_BUILD, '0, '0, '0, 48'd1100);
    send_beat(offs_pkg::OP_REMOVE, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                         counted;
    int                         pick;
    logic [offs_pkg::OpW-1:0]   op;
    logic [offs_pkg::CamW-1:0]  cam;
    logic [offs_pkg::TimeW-1:0] age;
    logic [offs_pkg::TimeW-1:0] now;
    counted    = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    clock_now  = 48'd2000;
    while (counted < n_items) begin
      // Run the opening stretch without any idling
      if (counted == SteadyItems) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 52)      op = offs_pkg::OP_UPDATE;
      else if (pick < 78) op = offs_pkg::OP_BUILD;
      else if (pick < 94) op = offs_pkg::OP_REMOVE;
      else                op = OpUnused;
      cam = ($urandom_range(99) < 8)
          ? offs_pkg::CamW'($urandom_range(7, offs_pkg::NumCameras))
          : offs_pkg::CamW'($urandom_range(offs_pkg::NumCameras - 1));
      // Small time steps give ties; rare jumps cover wide and backward times
      if ($urandom_range(99) < 10) clock_now = wide_time();
      else                         clock_now = clock_now + offs_pkg::TimeW'($urandom_range(3));
      now = clock_now;
      case ($urandom_range(9))
        0:       age = wide_time();
        1:       age = now + offs_pkg::TimeW'($urandom_range(50, 1));
        default: age = offs_pkg::TimeW'($urandom_range(40));
      endcase
      send_beat(op, cam, age, $urandom, now);
      if (!(op == OpUnused || (op == offs_pkg::OP_UPDATE && cam >= offs_pkg::NumCameras)))
        counted++;
    end
  endtask

  initial begin
    for (int i = 0; i < offs_pkg::NumCameras; i++) begin
      slot_live[i]     = 1'b0;
      slot_taken_at[i] = '0;
      slot_data[i]     = '0;
    end
    sent_set = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_output_hold_off();
    test_random_traffic(RandomItems);
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_beats.size() != 0)
      report_mismatch("results left pending", 64'(pending_beats.size()), 64'd0);

    if (mismatch_count == 0) begin
      $display("[oldest_first_frame_selector] OK");
    end else begin
      $display("[oldest_first_frame_selector] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/offs_pkg.sv
rtl/core/offs_dpath.sv
rtl/core/offs_ctrl.sv
rtl/core/oldest_first_frame_selector.sv
rtl/core/offs_checker.sv
tb/sv/testbench.sv
